>>> src/kclpd_pkg.sv
// ----------------------------------------------------------------------------
// kclpd_pkg
// Shared types and constants for the key click / long press detector.
// ----------------------------------------------------------------------------
package kclpd_pkg;

  // debounce sampling period in ticks
  localparam int unsigned DEBOUNCE_TICKS = 20;
  localparam int unsigned DBC_W          = 5;

  localparam int unsigned FLAG_W  = 7;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned CFG_AW  = 2;
  localparam int unsigned IN_DW   = 8;
  localparam int unsigned OUT_DW  = 16;

  // flag bit positions
  localparam int unsigned FB_HOLD   = 0;
  localparam int unsigned FB_DOWN   = 1;
  localparam int unsigned FB_UP     = 2;
  localparam int unsigned FB_SINGLE = 3;
  localparam int unsigned FB_DOUBLE = 4;
  localparam int unsigned FB_LONG   = 5;
  localparam int unsigned FB_REPEAT = 6;

  localparam logic [FLAG_W-1:0] FLAG_HOLD = 7'h01;

  // item kinds carried on tuser
  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_CHECK = 1'b1
  } op_t;

  // configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    CFG_DOUBLE_WIN  = 2'd0,
    CFG_LONG_TIME   = 2'd1,
    CFG_REPEAT_INTV = 2'd2
  } cfg_idx_t;

  // press phase machine
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HELD   = 3'd1,
    PH_WAIT   = 3'd2,
    PH_SECOND = 3'd3,
    PH_REPEAT = 3'd4
  } phase_t;

endpackage

>>> src/key_click_long_press_detector.sv
// The result of an input transfer is registered and shows on the output in the cycle after it.
// Throughput: one item per cycle; the input stalls only while a result is held
// back by out_tready, since the single output register is the only buffer.
// Reset (rst_n low at a clock edge): flags, levels, phase, countdown and debounce
// counter clear to zero; timing registers load 200, 1000 and 100 ticks.
// ----------------------------------------------------------------------------
// key_click_long_press_detector
// Debounced push-button qualifier raising hold, edge, single, double, long and
// repeat flags, with a check-and-clear operation on a flag mask.
// ----------------------------------------------------------------------------
module key_click_long_press_detector (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [kclpd_pkg::IN_DW-1:0]         in_tdata,   // [0] key_level, [7:1] flag_mask
  input  logic                                in_tuser,   // [0] operation
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [kclpd_pkg::OUT_DW-1:0]        out_tdata,  // [0] status, [1] flag_set,
                                                          // [8:2] flags_now, [15:9] zero
  // configuration writes
  input  logic                                cfg_we,
  input  logic [kclpd_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [kclpd_pkg::CNT_W-1:0]         cfg_wdata
);
  import kclpd_pkg::*;

  // configuration registers
  logic [CNT_W-1:0]  dbl_win_r, long_time_r, rep_intv_r;

  // detector state
  logic [FLAG_W-1:0] flags_r, flags_nxt;
  logic              lvl_now_r, lvl_now_nxt;
  logic              lvl_before_r, lvl_before_nxt;
  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  cdown_r, cdown_nxt;
  logic [DBC_W-1:0]  dbc_r, dbc_nxt;

  // result register
  logic              out_valid_r;
  logic              status_r, status_nxt;
  logic              set_r, set_nxt;

  // input fields
  op_t               op;
  logic              key_level;
  logic [FLAG_W-1:0] mask;
  logic              in_xfer;

  // tick intermediates
  logic [CNT_W-1:0]  cdown_dec;
  logic [DBC_W-1:0]  dbc_inc;
  logic              sample;
  logic [FLAG_W-1:0] flags_smp;
  logic              hit;

  assign op        = op_t'(in_tuser);
  assign key_level = in_tdata[0];
  assign mask      = in_tdata[FLAG_W:1];
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  // configuration write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbl_win_r   <= 16'd200;
      long_time_r <= 16'd1000;
      rep_intv_r  <= 16'd100;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_DOUBLE_WIN:  dbl_win_r   <= cfg_wdata;
        CFG_LONG_TIME:   long_time_r <= cfg_wdata;
        CFG_REPEAT_INTV: rep_intv_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // next state and result for one item
  always_comb begin
    cdown_dec = (cdown_r != '0) ? cdown_r - 1'b1 : cdown_r;
    dbc_inc   = dbc_r + 1'b1;
    sample    = (dbc_inc >= DBC_W'(DEBOUNCE_TICKS));
    hit       = (flags_r & mask) != '0;

    flags_nxt      = flags_r;
    lvl_now_nxt    = lvl_now_r;
    lvl_before_nxt = lvl_before_r;
    phase_nxt      = phase_r;
    cdown_nxt      = cdown_r;
    dbc_nxt        = dbc_r;
    status_nxt     = 1'b0;
    set_nxt        = 1'b0;
    flags_smp      = flags_r;

    case (op)
      OP_TICK: begin
        cdown_nxt = cdown_dec;
        if (!sample) begin
          dbc_nxt    = dbc_inc;
          status_nxt = 1'b1;
        end else begin
          dbc_nxt        = '0;
          lvl_before_nxt = lvl_now_r;
          lvl_now_nxt    = key_level;
          // level and edge flags
          flags_smp[FB_HOLD] = key_level;
          if (key_level && !lvl_now_r) flags_smp[FB_DOWN] = 1'b1;
          if (!key_level && lvl_now_r) flags_smp[FB_UP]   = 1'b1;
          // press phase machine, timed by the decremented countdown
          case (phase_r)
            PH_IDLE: begin
              if (key_level) begin
                cdown_nxt = long_time_r;
                phase_nxt = PH_HELD;
              end
            end
            PH_HELD: begin
              if (!key_level) begin
                cdown_nxt = dbl_win_r;
                phase_nxt = PH_WAIT;
              end else if (cdown_dec == '0) begin
                cdown_nxt          = rep_intv_r;
                flags_smp[FB_LONG] = 1'b1;
                phase_nxt          = PH_REPEAT;
              end
            end
            PH_WAIT: begin
              if (key_level) begin
                flags_smp[FB_DOUBLE] = 1'b1;
                phase_nxt            = PH_SECOND;
              end else if (cdown_dec == '0) begin
                flags_smp[FB_SINGLE] = 1'b1;
                phase_nxt            = PH_IDLE;
              end
            end
            PH_SECOND: begin
              if (!key_level) phase_nxt = PH_IDLE;
            end
            PH_REPEAT: begin
              if (!key_level) begin
                phase_nxt = PH_IDLE;
              end else if (cdown_dec == '0) begin
                cdown_nxt            = rep_intv_r;
                flags_smp[FB_REPEAT] = 1'b1;
              end
            end
            default: phase_nxt = PH_IDLE;
          endcase
          flags_nxt = flags_smp;
        end
      end
      OP_CHECK: begin
        set_nxt = hit;
        if (hit && (mask != FLAG_HOLD)) flags_nxt = flags_r & ~mask;
      end
      default: ;
    endcase
  end

  // state registers, updated on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r      <= '0;
      lvl_now_r    <= 1'b0;
      lvl_before_r <= 1'b0;
      phase_r      <= PH_IDLE;
      cdown_r      <= '0;
      dbc_r        <= '0;
    end else if (in_xfer) begin
      flags_r      <= flags_nxt;
      lvl_now_r    <= lvl_now_nxt;
      lvl_before_r <= lvl_before_nxt;
      phase_r      <= phase_nxt;
      cdown_r      <= cdown_nxt;
      dbc_r        <= dbc_nxt;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      status_r <= status_nxt;
      set_r    <= set_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DW-FLAG_W-2){1'b0}}, flags_r, set_r, status_r};

  // a result never reports both a skipped tick and a matched check
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("status and flag_set both high");

  // the debounce counter stays below its sampling period
  assert property (@(posedge clk) disable iff (!rst_n)
    dbc_r < DBC_W'(DEBOUNCE_TICKS))
    else $error("debounce counter out of range");

  // a matched check with a mask other than hold clears every masked flag
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && op == OP_CHECK && hit && mask != FLAG_HOLD)
      |=> ((flags_r & $past(mask)) == '0))
    else $error("masked flags not cleared after check");

  // a sampled tick restarts the debounce counter
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && op == OP_TICK && sample) |=> (dbc_r == '0 && !status_r))
    else $error("debounce counter not restarted on sample");

endmodule

>>> sim/key_click_long_press_detector_test.sv
// ----------------------------------------------------------------------------
// key_click_long_press_detector_test
// Self-checking bench for the key click / long press detector: drives tick
// and check transfers with random pacing on both streams, predicts every
// result from a local model of the debounce, phase machine and flag register,
// and compares each output transfer field by field.
// ----------------------------------------------------------------------------
module key_click_long_press_detector_test;
  import kclpd_pkg::*;

  // one output transfer, laid out as on out_tdata[8:0]
  typedef struct packed {
    logic [FLAG_W-1:0] flags_now;
    logic              flag_set;
    logic              status;
  } key_report_t;

  class press_scoreboard;
    // timing registers
    logic [CNT_W-1:0]  win_ticks;
    logic [CNT_W-1:0]  long_ticks;
    logic [CNT_W-1:0]  rpt_ticks;
    // detector state
    logic [FLAG_W-1:0] flags;
    logic              lvl_now;
    logic              lvl_prev;
    phase_t            phase;
    logic [CNT_W-1:0]  timer;
    logic [DBC_W-1:0]  sample_cnt;

    key_report_t       expected_reports[$];
    int                mismatches;

    function new();
      win_ticks  = 16'd200;
      long_ticks = 16'd1000;
      rpt_ticks  = 16'd100;
      flags      = '0;
      lvl_now    = 1'b0;
      lvl_prev   = 1'b0;
      phase      = PH_IDLE;
      timer      = '0;
      sample_cnt = '0;
      mismatches = 0;
    endfunction

    function void set_timing(logic [CNT_W-1:0] win, logic [CNT_W-1:0] lng,
                             logic [CNT_W-1:0] rpt);
      win_ticks  = win;
      long_ticks = lng;
      rpt_ticks  = rpt;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function void log_error(string msg);
      mismatches++;
      if (mismatches <= 10)
        $display("%s", msg);
    endfunction

    // press phase machine, run once per debounced sample
    function void step_press_phase();
      case (phase)
        PH_IDLE: begin
          if (lvl_now) begin
            timer = long_ticks;
            phase = PH_HELD;
          end
        end
        PH_HELD: begin
          if (!lvl_now) begin
            timer = win_ticks;
            phase = PH_WAIT;
          end else if (timer == 0) begin
            timer          = rpt_ticks;
            flags[FB_LONG] = 1'b1;
            phase          = PH_REPEAT;
          end
        end
        PH_WAIT: begin
          if (lvl_now) begin
            flags[FB_DOUBLE] = 1'b1;
            phase            = PH_SECOND;
          end else if (timer == 0) begin
            flags[FB_SINGLE] = 1'b1;
            phase            = PH_IDLE;
          end
        end
        PH_SECOND: begin
          if (!lvl_now)
            phase = PH_IDLE;
        end
        PH_REPEAT: begin
          if (!lvl_now) begin
            phase = PH_IDLE;
          end else if (timer == 0) begin
            timer            = rpt_ticks;
            flags[FB_REPEAT] = 1'b1;
          end
        end
        default: phase = PH_IDLE;
      endcase
    endfunction

    // accepted input transfer: update state and queue the expected report
    function void note_transfer(op_t op, logic lvl, logic [FLAG_W-1:0] mask);
      key_report_t rep;
      rep = '0;
      if (op == OP_TICK) begin
        if (timer != 0)
          timer = timer - 1'b1;
        sample_cnt = sample_cnt + 1'b1;
        if (sample_cnt < DEBOUNCE_TICKS) begin
          rep.status = 1'b1;
        end else begin
          sample_cnt     = '0;
          lvl_prev       = lvl_now;
          lvl_now        = lvl;
          flags[FB_HOLD] = lvl_now;
          if (lvl_now && !lvl_prev)
            flags[FB_DOWN] = 1'b1;
          if (!lvl_now && lvl_prev)
            flags[FB_UP] = 1'b1;
          step_press_phase();
        end
      end else begin
        // check and clear, hold alone is only reported
        if ((flags & mask) != 0) begin
          if (mask != FLAG_HOLD)
            flags = flags & ~mask;
          rep.flag_set = 1'b1;
        end
      end
      rep.flags_now = flags;
      expected_reports.push_back(rep);
    endfunction

    // accepted output transfer: compare with the oldest expected report
    function void check_result(logic [OUT_DW-1:0] data);
      key_report_t want;
      key_report_t got;
      got = data[8:0];
      if (expected_reports.size() == 0) begin
        log_error($sformatf("unexpected result %04h", data));
        return;
      end
      want = expected_reports.pop_front();
      if (got.status !== want.status || got.flag_set !== want.flag_set ||
          got.flags_now !== want.flags_now || data[OUT_DW-1:9] !== '0)
        log_error($sformatf({"mismatch: status exp %0b got %0b, flag_set exp %0b got %0b, ",
                             "flags_now exp %02h got %02h, pad got %02h"},
                            want.status, got.status, want.flag_set, got.flag_set,
                            want.flags_now, got.flags_now, data[OUT_DW-1:9]));
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 90;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [IN_DW-1:0]   in_tdata   = '0;  // [0] key_level, [7:1] flag_mask
  logic               in_tuser   = 1'b0; // [0] operation
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [OUT_DW-1:0]  out_tdata;         // [0] status, [1] flag_set, [8:2] flags_now
  logic               cfg_we     = 1'b0;
  logic [CFG_AW-1:0]  cfg_addr   = '0;
  logic [CNT_W-1:0]   cfg_wdata  = '0;

  press_scoreboard sb = new();
  bit              tx_steady = 1'b0;
  bit              rx_steady = 1'b0;
  int              rx_hold   = 0;
  int              cycles    = 0;

  key_click_long_press_detector i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("key_click_long_press_detector test failed");
      $finish;
    end
  end

  // result side pacing: a random stall of out_tready after each transfer, none while rx_steady
  always @(posedge clk) begin : rx_pace
    int stall;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_hold    <= 0;
    end else if (out_tvalid && out_tready) begin
      stall = rx_steady ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_tready <= 1'b0;
        rx_hold    <= stall;
      end
    end else if (rx_hold > 1) begin
      rx_hold <= rx_hold - 1;
    end else begin
      rx_hold    <= 0;
      out_tready <= 1'b1;
    end
  end

  // monitor both streams, input first so a same-edge result finds its entry
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_transfer(op_t'(in_tuser), in_tdata[0], in_tdata[IN_DW-1:1]);
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata);
  end

  // one input transfer with a random gap ahead of it
  task automatic send_item(input op_t op, input logic lvl, input logic [FLAG_W-1:0] mask);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {mask, lvl};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
  endtask

  // write all three timing registers back to back
  task automatic write_timing(input logic [CNT_W-1:0] win, input logic [CNT_W-1:0] lng,
                              input logic [CNT_W-1:0] rpt);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_DOUBLE_WIN;
    cfg_wdata <= win;
    @(posedge clk);
    cfg_addr  <= CFG_LONG_TIME;
    cfg_wdata <= lng;
    @(posedge clk);
    cfg_addr  <= CFG_REPEAT_INTV;
    cfg_wdata <= rpt;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_timing(win, lng, rpt);
  endtask

  // stop sending and wait for every expected result plus a few cycles
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic [FLAG_W-1:0] pick_mask();
    case ($urandom_range(0, 7))
      0:       return FLAG_HOLD;
      1:       return '0;
      2:       return 7'h7f;
      3, 4:    return 7'(1 << $urandom_range(0, 6));
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  // press and release segments with sprinkled checks, some bouncing noise
  task automatic run_phase(input int budget);
    int   done;
    int   seg_len;
    bit   noisy;
    logic seg_lvl;
    logic lvl;
    done    = 0;
    seg_lvl = 1'b0;
    while (done < budget) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) != 0) begin
        seg_lvl = ~seg_lvl;
        seg_len = $urandom_range(5, 160);
        noisy   = 1'b0;
      end else begin
        seg_len = $urandom_range(5, 40);
        noisy   = 1'b1;
      end
      for (int i = 0; i < seg_len; i++) begin
        if ($urandom_range(0, 7) == 0) begin
          send_item(OP_CHECK, 1'($urandom_range(0, 1)), pick_mask());
          done++;
        end
        lvl = noisy ? 1'($urandom_range(0, 1)) : seg_lvl;
        send_item(OP_TICK, lvl, 7'($urandom_range(0, 127)));
        done++;
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    logic [CNT_W-1:0] win;
    logic [CNT_W-1:0] lng;
    logic [CNT_W-1:0] rpt;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty and full masks on a clear register, ignored fields,
    // first debounced press, hold-only check, multi-bit clear
    send_item(OP_CHECK, 1'b1, 7'h00);
    send_item(OP_CHECK, 1'b0, 7'h7f);
    for (int i = 0; i < 19; i++)
      send_item(OP_TICK, 1'b1, (i % 2) ? 7'h7f : 7'h00);
    send_item(OP_TICK, 1'b1, 7'h55);
    send_item(OP_CHECK, 1'b1, FLAG_HOLD);
    send_item(OP_CHECK, 1'b0, 7'h06);
    send_item(OP_CHECK, 1'b1, 7'h7f);
    drain();

    // random phases: all-zero timing, all-ones timing, then short timings
    for (int p = 0; p < 6; p++) begin
      if (p == 0) begin
        win = '0;
        lng = '0;
        rpt = '0;
      end else if (p == 1) begin
        win = '1;
        lng = '1;
        rpt = '1;
      end else begin
        win = 16'($urandom_range(0, 80));
        lng = 16'($urandom_range(0, 150));
        rpt = 16'($urandom_range(0, 60));
      end
      write_timing(win, lng, rpt);
      run_phase(PHASE_ITEMS);
      drain();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("key_click_long_press_detector test passed");
    end else begin
      $display("key_click_long_press_detector test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/kclpd_pkg.sv
src/key_click_long_press_detector.sv
sim/key_click_long_press_detector_test.sv
